FILE: design/plst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg
// Shared codes, widths and the cell control bundle of the positional list store
// ----------------------------------------------------------------------------
package plst_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int OP_W         = 3;
   localparam int POS_W        = 8;
   localparam int STATUS_W     = 3;
   localparam int FOUND_W      = 4;
   localparam int COUNT_OUT_W  = 5;
   localparam int CNT_MAX_W    = 9;
   localparam int SCAN_CHUNK   = 16;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic                 commit;
      logic                 ins;
      logic                 del;
      logic                 search;
      logic [POS_W-1:0]     where;
      logic [CNT_MAX_W-1:0] count;
      logic [DATA_W-1:0]    value;
   } cell_ctl_type;

endpackage

FILE: design/plst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_cell
// One entry of the list: holds a value, shifts up or down with its neighbours
// ----------------------------------------------------------------------------
module plst_cell #(
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  plst_pkg::cell_ctl_type           ctl,
   input  logic [plst_pkg::DATA_W-1:0]      lower_data,
   input  logic [plst_pkg::DATA_W-1:0]      upper_data,
   output logic [plst_pkg::DATA_W-1:0]      data,
   output logic                             hit,
   output logic [plst_pkg::DATA_W-1:0]      tap
);

   localparam logic [plst_pkg::CNT_MAX_W-1:0] MY_IDX = plst_pkg::CNT_MAX_W'(INDEX);

   logic [plst_pkg::DATA_W-1:0] data_ff;
   logic [plst_pkg::DATA_W-1:0] data_in;
   logic                        at_where;
   logic                        above_where;

   assign at_where    = MY_IDX == {1'b0, ctl.where};
   assign above_where = MY_IDX > {1'b0, ctl.where};

   always_comb begin
      data_in = data_ff;
      if (ctl.commit && ctl.ins) begin
         if (above_where) begin
            data_in = lower_data;
         end else if (at_where) begin
            data_in = ctl.value;
         end
      end else if (ctl.commit && ctl.del && (above_where || at_where)) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      hit = 1'b0;
      if (ctl.search) begin
         hit = (data_ff == ctl.value) && (MY_IDX < ctl.count);
      end else if (ctl.del) begin
         hit = at_where;
      end
   end

   assign tap  = (ctl.del && at_where) ? data_ff : '0;
   assign data = data_ff;

endmodule

FILE: design/plst_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_scan
// Walks the cell hit flags a chunk per cycle: first hit index and removed value
// ----------------------------------------------------------------------------
module plst_scan #(
   parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic                                hits [CAPACITY],
   input  logic [plst_pkg::DATA_W-1:0]         taps [CAPACITY],
   output logic                                busy,
   output logic                                found,
   output logic [$clog2(CAPACITY)-1:0]         index,
   output logic [plst_pkg::DATA_W-1:0]         removed
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CHUNK = (CAPACITY < plst_pkg::SCAN_CHUNK) ? CAPACITY : plst_pkg::SCAN_CHUNK;
   localparam int NCH   = (CAPACITY + CHUNK - 1) / CHUNK;
   localparam int NT    = NCH * CHUNK;
   localparam int SW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int KW    = $clog2(CHUNK);

   logic                        hit_pad [NT];
   logic [plst_pkg::DATA_W-1:0] tap_pad [NT];
   logic                        hit_sh_ff [NT];
   logic [plst_pkg::DATA_W-1:0] tap_sh_ff [NT];
   logic                        busy_ff;
   logic [SW-1:0]               step_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            index_ff;
   logic [plst_pkg::DATA_W-1:0] acc_ff;
   logic                        chunk_any;
   logic [KW-1:0]               chunk_k;
   logic [plst_pkg::DATA_W-1:0] chunk_or;
   logic [31:0]                 index_wide;

   for (genvar g = 0; g < NT; g++) begin : g_pad
      if (g < CAPACITY) begin : g_live
         assign hit_pad[g] = hits[g];
         assign tap_pad[g] = taps[g];
      end else begin : g_fill
         assign hit_pad[g] = 1'b0;
         assign tap_pad[g] = '0;
      end
   end

   // first hit in the lowest chunk
   always_comb begin
      chunk_any = 1'b0;
      chunk_k   = '0;
      chunk_or  = '0;
      for (int k = CHUNK - 1; k >= 0; k--) begin
         if (hit_sh_ff[k]) begin
            chunk_any = 1'b1;
            chunk_k   = KW'(k);
         end
         chunk_or = chunk_or | tap_sh_ff[k];
      end
   end

   assign index_wide = 32'(step_ff) * CHUNK + 32'(chunk_k);

   always_ff @(posedge clock) begin
      if (load) begin
         for (int j = 0; j < NT; j++) begin
            hit_sh_ff[j] <= hit_pad[j];
            tap_sh_ff[j] <= tap_pad[j];
         end
         acc_ff   <= '0;
         index_ff <= '0;
      end else if (busy_ff) begin
         for (int j = 0; j < NT; j++) begin
            if (j + CHUNK < NT) begin
               hit_sh_ff[j] <= hit_sh_ff[(j + CHUNK) % NT];
               tap_sh_ff[j] <= tap_sh_ff[(j + CHUNK) % NT];
            end else begin
               hit_sh_ff[j] <= 1'b0;
               tap_sh_ff[j] <= '0;
            end
         end
         acc_ff <= acc_ff | chunk_or;
         if (!found_ff && chunk_any) begin
            index_ff <= index_wide[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         found_ff <= 1'b0;
      end else if (load) begin
         busy_ff  <= 1'b1;
         step_ff  <= '0;
         found_ff <= 1'b0;
      end else if (busy_ff) begin
         step_ff  <= step_ff + 1'b1;
         found_ff <= found_ff | chunk_any;
         if (step_ff == SW'(NCH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy    = busy_ff;
   assign found   = found_ff;
   assign index   = index_ff;
   assign removed = acc_ff;

endmodule

FILE: design/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells
// ----------------------------------------------------------------------------
// Each request transfer carries one operation (insert front, back or at a
// position, delete front, back or at a position, or search for a value) and
// gives exactly one response transfer with the removed value, the first
// matching index, the new entry count and a status code. Every cell compares
// against the request in parallel; the hit flags are then walked sixteen cells
// per cycle. A request transfer passes through the chunk walk, a hand-over to
// the commit, and then the cell shift with the registered response. One item
// is in flight at a time, so no new request is taken until the previous one
// has been committed and its response registered, and a stall on the response
// side holds it off further. The next request is taken while an earlier
// response is still waiting. No clearing is needed after reset.
module positional_list_store #(
   parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [plst_pkg::OP_W-1:0]                   req_operation,
   input  logic signed [plst_pkg::DATA_W-1:0]          req_value,
   input  logic [plst_pkg::POS_W-1:0]                  req_position,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [plst_pkg::DATA_W-1:0]          rsp_removed_value,
   output logic [plst_pkg::FOUND_W-1:0]                rsp_found_index,
   output logic [plst_pkg::COUNT_OUT_W-1:0]            rsp_entry_count,
   output logic [plst_pkg::STATUS_W-1:0]               rsp_status
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic                                ins_ff, ins_in;
   logic                                del_ff, del_in;
   logic                                srch_ff, srch_in;
   logic [plst_pkg::DATA_W-1:0]         value_ff, value_in;
   logic [plst_pkg::POS_W-1:0]          where_ff, where_in;
   logic [plst_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [plst_pkg::DATA_W-1:0]         rsp_removed_ff, rsp_removed_in;
   logic [plst_pkg::FOUND_W-1:0]        rsp_found_ff, rsp_found_in;
   logic [plst_pkg::COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [plst_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic [plst_pkg::CNT_MAX_W-1:0]      count9;
   logic [plst_pkg::CNT_MAX_W-1:0]      where9;
   logic                                req_ins, req_del, req_srch;
   logic                                accept, can_out, commit, ok;
   logic                                scan_busy, scan_found;
   logic [IDX_W-1:0]                    scan_index;
   logic [plst_pkg::DATA_W-1:0]         scan_removed;
   logic [CNT_W-1:0]                    new_count;
   logic [31:0]                         count_wide, index_wide;
   plst_pkg::cell_ctl_type              ctl;

   logic [plst_pkg::DATA_W-1:0]         cell_data [CAPACITY];
   logic                                cell_hit  [CAPACITY];
   logic [plst_pkg::DATA_W-1:0]         cell_tap  [CAPACITY];

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign can_out   = !(rsp_valid_ff && rsp_stall);
   assign count9    = plst_pkg::CNT_MAX_W'(count_ff);

   assign req_ins  = (req_operation == plst_pkg::OP_INS_FRONT)
                  || (req_operation == plst_pkg::OP_INS_BACK)
                  || (req_operation == plst_pkg::OP_INS_POS);
   assign req_del  = (req_operation == plst_pkg::OP_DEL_FRONT)
                  || (req_operation == plst_pkg::OP_DEL_BACK)
                  || (req_operation == plst_pkg::OP_DEL_POS);
   assign req_srch = req_operation == plst_pkg::OP_SEARCH;

   // target index and early status of the request
   always_comb begin
      where9    = '0;
      status_in = plst_pkg::ST_OK;
      unique case (req_operation)
         plst_pkg::OP_INS_FRONT: where9 = '0;
         plst_pkg::OP_INS_BACK:  where9 = count9;
         plst_pkg::OP_INS_POS:   where9 = plst_pkg::CNT_MAX_W'(req_position);
         plst_pkg::OP_DEL_FRONT: where9 = '0;
         plst_pkg::OP_DEL_BACK:  where9 = (count9 == '0) ? '0 : count9 - 1'b1;
         plst_pkg::OP_DEL_POS:   where9 = plst_pkg::CNT_MAX_W'(req_position);
         default:                where9 = '0;
      endcase
      if (req_ins) begin
         if (where9 > count9) begin
            status_in = plst_pkg::ST_BADPOS;
         end else if (count9 >= plst_pkg::CNT_MAX_W'(CAPACITY)) begin
            status_in = plst_pkg::ST_FULL;
         end
      end else if (req_del) begin
         if (count9 == '0) begin
            status_in = plst_pkg::ST_EMPTY;
         end else if (where9 >= count9) begin
            status_in = plst_pkg::ST_BADPOS;
         end
      end
   end

   assign ok     = status_ff == plst_pkg::ST_OK;
   assign commit = (state_ff == ST_DONE) && can_out && ok && (ins_ff || del_ff);

   always_comb begin
      ctl.commit = commit;
      ctl.count  = count9;
      if (state_ff == ST_IDLE) begin
         ctl.ins    = req_ins;
         ctl.del    = req_del;
         ctl.search = req_srch;
         ctl.where  = where9[plst_pkg::POS_W-1:0];
         ctl.value  = req_value;
      end else begin
         ctl.ins    = ins_ff;
         ctl.del    = del_ff;
         ctl.search = srch_ff;
         ctl.where  = where_ff;
         ctl.value  = value_ff;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [plst_pkg::DATA_W-1:0] lower, upper;
      if (g == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid_hi
         assign upper = cell_data[g+1];
      end
      plst_cell #(
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[g]),
         .hit        (cell_hit[g]),
         .tap        (cell_tap[g])
      );
   end

   plst_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .hits    (cell_hit),
      .taps    (cell_tap),
      .busy    (scan_busy),
      .found   (scan_found),
      .index   (scan_index),
      .removed (scan_removed)
   );

   always_comb begin
      new_count = count_ff;
      if (ok && ins_ff) begin
         new_count = count_ff + 1'b1;
      end else if (ok && del_ff) begin
         new_count = count_ff - 1'b1;
      end
   end

   assign count_wide = 32'(new_count);
   assign index_wide = 32'(scan_index);

   always_comb begin
      state_in       = state_ff;
      ins_in         = ins_ff;
      del_in         = del_ff;
      srch_in        = srch_ff;
      value_in       = value_ff;
      where_in       = where_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ins_in   = req_ins;
               del_in   = req_del;
               srch_in  = req_srch;
               value_in = req_value;
               where_in = where9[plst_pkg::POS_W-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (can_out) begin
               count_in       = new_count;
               rsp_valid_in   = 1'b1;
               rsp_removed_in = (ok && del_ff) ? scan_removed : '0;
               rsp_found_in   = (srch_ff && scan_found) ?
                                index_wide[plst_pkg::FOUND_W-1:0] : '0;
               rsp_count_in   = count_wide[plst_pkg::COUNT_OUT_W-1:0];
               rsp_status_in  = status_ff;
               if (srch_ff) begin
                  rsp_status_in = scan_found ? plst_pkg::ST_OK : plst_pkg::ST_NOTFOUND;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff         <= ins_in;
      del_ff         <= del_in;
      srch_ff        <= srch_in;
      value_ff       <= value_in;
      where_ff       <= where_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_found_index   = rsp_found_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

FILE: design/plst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_checker
// Port-level checks on the response channel of the positional list store
// ----------------------------------------------------------------------------
module plst_checker #(
   parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [plst_pkg::DATA_W-1:0]           rsp_removed_value,
   input logic [plst_pkg::FOUND_W-1:0]          rsp_found_index,
   input logic [plst_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   input logic [plst_pkg::STATUS_W-1:0]         rsp_status
);

   localparam logic [plst_pkg::COUNT_OUT_W-1:0] FULL_CNT = plst_pkg::COUNT_OUT_W'(CAPACITY);

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_fail_no_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != plst_pkg::ST_OK) |-> rsp_removed_value == '0)
      else $error("removed value on failed operation");

   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != plst_pkg::ST_OK) |-> rsp_found_index == '0)
      else $error("found index on failed operation");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == plst_pkg::ST_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with entries present");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == plst_pkg::ST_FULL) |-> rsp_entry_count == FULL_CNT)
      else $error("full status below capacity");

endmodule

bind positional_list_store plst_checker #(
   .CAPACITY (CAPACITY)
) u_plst_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_removed_value (rsp_removed_value),
   .rsp_found_index   (rsp_found_index),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_status        (rsp_status)
);

FILE: sim/positional_list_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Self-checking testbench for the positional list store
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed run over the empty,
// extreme-value and bad-position corners, then random traffic that swings the list
// between empty and full, with values drawn from a small pool so that
// searches hit and duplicates appear. A clocked driver presents the requests
// with random idle bursts, and an internal model of the list predicts one
// response per accepted request. A clocked monitor stalls the response side
// in random bursts and checks every response field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module positional_list_store_tb;

   localparam int                        CAPACITY     = plst_pkg::CAPACITY_DEF;
   localparam int                        RANDOM_ITEMS = 1830;
   localparam int                        TAIL_ITEMS   = 200;
   localparam int                        DRAIN_CYCLES = 20;
   localparam logic [plst_pkg::OP_W-1:0] OP_UNUSED    = 3'd7;

   typedef struct packed {
      logic [plst_pkg::OP_W-1:0]          operation;
      logic signed [plst_pkg::DATA_W-1:0] value;
      logic [plst_pkg::POS_W-1:0]         position;
   } list_request_type;

   typedef struct packed {
      logic signed [plst_pkg::DATA_W-1:0] removed_value;
      logic [plst_pkg::FOUND_W-1:0]       found_index;
      logic [plst_pkg::COUNT_OUT_W-1:0]   entry_count;
      logic [plst_pkg::STATUS_W-1:0]      status;
   } list_outcome_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [plst_pkg::OP_W-1:0]           req_operation = '0;
   logic signed [plst_pkg::DATA_W-1:0]  req_value = '0;
   logic [plst_pkg::POS_W-1:0]          req_position = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [plst_pkg::DATA_W-1:0]  rsp_removed_value;
   logic [plst_pkg::FOUND_W-1:0]        rsp_found_index;
   logic [plst_pkg::COUNT_OUT_W-1:0]    rsp_entry_count;
   logic [plst_pkg::STATUS_W-1:0]       rsp_status;

   list_request_type                    pending_requests[$];
   list_outcome_type                    expected_outcomes[$];
   logic signed [plst_pkg::DATA_W-1:0]  list_model[CAPACITY];
   int                                  list_len = 0;
   int                                  fill_level = 0;
   int                                  queued_total = 0;
   int                                  accepted_total = 0;
   int                                  mismatch_count = 0;
   int                                  idle_left = 0;
   int                                  stall_left = 0;
   list_request_type                    next_request;
   list_outcome_type                    oldest_outcome;

   positional_list_store #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_removed_value(rsp_removed_value),
      .rsp_found_index(rsp_found_index),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
   endtask

   // list model: works out the response of one accepted transfer
   task automatic forecast_outcome(input logic [plst_pkg::OP_W-1:0] op,
                                   input logic signed [plst_pkg::DATA_W-1:0] val,
                                   input logic [plst_pkg::POS_W-1:0] pos);
      list_outcome_type outcome;
      int               where;
      outcome = '0;
      outcome.status = plst_pkg::ST_OK;
      case (op)
         plst_pkg::OP_INS_FRONT, plst_pkg::OP_INS_BACK, plst_pkg::OP_INS_POS: begin
            where = (op == plst_pkg::OP_INS_FRONT) ? 0 :
                    (op == plst_pkg::OP_INS_BACK) ? list_len : int'(pos);
            if (where > list_len) begin
               outcome.status = plst_pkg::ST_BADPOS;
            end else if (list_len >= CAPACITY) begin
               outcome.status = plst_pkg::ST_FULL;
            end else begin
               for (int i = list_len; i > where; i--) list_model[i] = list_model[i-1];
               list_model[where] = val;
               list_len++;
            end
         end
         plst_pkg::OP_DEL_FRONT, plst_pkg::OP_DEL_BACK, plst_pkg::OP_DEL_POS: begin
            where = (op == plst_pkg::OP_DEL_FRONT) ? 0 :
                    (op == plst_pkg::OP_DEL_BACK) ? list_len - 1 : int'(pos);
            if (list_len == 0) begin
               outcome.status = plst_pkg::ST_EMPTY;
            end else if (where >= list_len) begin
               outcome.status = plst_pkg::ST_BADPOS;
            end else begin
               outcome.removed_value = list_model[where];
               for (int i = where; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
               list_len--;
            end
         end
         plst_pkg::OP_SEARCH: begin
            outcome.status = plst_pkg::ST_NOTFOUND;
            for (int i = 0; i < list_len; i++) begin
               if (outcome.status == plst_pkg::ST_NOTFOUND && list_model[i] == val) begin
                  outcome.found_index = i[plst_pkg::FOUND_W-1:0];
                  outcome.status = plst_pkg::ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
      outcome.entry_count = list_len[plst_pkg::COUNT_OUT_W-1:0];
      expected_outcomes.push_back(outcome);
   endtask

   // queues a request and tracks the rough list level used to shape traffic
   task automatic queue_request(input logic [plst_pkg::OP_W-1:0] op,
                                input logic signed [plst_pkg::DATA_W-1:0] val,
                                input int pos);
      list_request_type item;
      int               where;
      item.operation = op;
      item.value = val;
      item.position = pos[plst_pkg::POS_W-1:0];
      pending_requests.push_back(item);
      queued_total++;
      if (op == plst_pkg::OP_INS_FRONT || op == plst_pkg::OP_INS_BACK
          || op == plst_pkg::OP_INS_POS) begin
         where = (op == plst_pkg::OP_INS_FRONT) ? 0 :
                 (op == plst_pkg::OP_INS_BACK) ? fill_level : pos;
         if (where <= fill_level && fill_level < CAPACITY) fill_level++;
      end else if (op == plst_pkg::OP_DEL_FRONT || op == plst_pkg::OP_DEL_BACK
                   || op == plst_pkg::OP_DEL_POS) begin
         where = (op == plst_pkg::OP_DEL_FRONT) ? 0 :
                 (op == plst_pkg::OP_DEL_BACK) ? fill_level - 1 : pos;
         if (fill_level > 0 && where < fill_level) fill_level--;
      end
   endtask

   function automatic logic signed [plst_pkg::DATA_W-1:0] pick_value();
      int k;
      k = $urandom_range(0, 5);
      if (k < 3) return $signed($urandom_range(0, 7)) - 3;
      if (k == 3) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic int pick_position(input int limit);
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return $urandom_range(0, limit);
      if (k == 6) return limit;
      if (k == 7) return (limit < 255) ? limit + 1 : limit;
      return $urandom_range(0, 255);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_total++;
            forecast_outcome(req_operation, req_value, req_position);
         end
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(1, 9) - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_request = pending_requests.pop_front();
               req_operation <= next_request.operation;
               req_value <= next_request.value;
               req_position <= next_request.position;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected response transfer, status", rsp_status, 0);
            end else begin
               oldest_outcome = expected_outcomes.pop_front();
               if (rsp_removed_value !== oldest_outcome.removed_value)
                  report_mismatch("removed_value", rsp_removed_value,
                                  oldest_outcome.removed_value);
               if (rsp_found_index !== oldest_outcome.found_index)
                  report_mismatch("found_index", rsp_found_index, oldest_outcome.found_index);
               if (rsp_entry_count !== oldest_outcome.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, oldest_outcome.entry_count);
               if (rsp_status !== oldest_outcome.status)
                  report_mismatch("status", rsp_status, oldest_outcome.status);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int trend;
      int insert_pct;
      int r;
      logic [plst_pkg::OP_W-1:0] op;

      // empty list corners
      queue_request(plst_pkg::OP_SEARCH, 32'sh0, 0);
      queue_request(plst_pkg::OP_DEL_FRONT, 32'sh0, 0);
      queue_request(plst_pkg::OP_DEL_BACK, 32'sh0, 0);
      queue_request(plst_pkg::OP_DEL_POS, 32'sh0, 0);
      queue_request(plst_pkg::OP_INS_POS, 32'sh5, 1);
      // extremes and positional inserts
      queue_request(plst_pkg::OP_INS_FRONT, 32'sh7fffffff, 0);
      queue_request(plst_pkg::OP_INS_BACK, 32'sh80000000, 0);
      queue_request(plst_pkg::OP_INS_POS, 32'sh0, 2);
      queue_request(plst_pkg::OP_INS_POS, -32'sd1, 0);
      queue_request(plst_pkg::OP_INS_POS, 32'sh55aa55aa, 255);
      queue_request(plst_pkg::OP_SEARCH, 32'sh80000000, 0);
      queue_request(plst_pkg::OP_SEARCH, 32'sh12345, 0);
      queue_request(plst_pkg::OP_DEL_POS, 32'sh0, 4);
      queue_request(plst_pkg::OP_DEL_POS, 32'sh0, 255);
      queue_request(OP_UNUSED, -32'sd1, 255);
      queue_request(plst_pkg::OP_DEL_POS, 32'sh0, 1);
      queue_request(plst_pkg::OP_DEL_FRONT, 32'sh0, 0);
      queue_request(plst_pkg::OP_DEL_BACK, 32'sh0, 0);

      // random traffic in phases that fill, drain or mix
      trend = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n > 0 && n % 60 == 0) trend = $urandom_range(0, 2);
         insert_pct = (trend == 0) ? 75 : (trend == 1) ? 25 : 50;
         r = $urandom_range(0, 99);
         if (r < 2) begin
            queue_request(OP_UNUSED, pick_value(), $urandom_range(0, 255));
         end else if (r < 17) begin
            queue_request(plst_pkg::OP_SEARCH, pick_value(), $urandom_range(0, 255));
         end else if ($urandom_range(0, 99) < insert_pct) begin
            case ($urandom_range(0, 2))
               0: op = plst_pkg::OP_INS_FRONT;
               1: op = plst_pkg::OP_INS_BACK;
               default: op = plst_pkg::OP_INS_POS;
            endcase
            queue_request(op, pick_value(),
                          (op == plst_pkg::OP_INS_POS) ? pick_position(fill_level)
                                                       : $urandom_range(0, 255));
         end else begin
            case ($urandom_range(0, 2))
               0: op = plst_pkg::OP_DEL_FRONT;
               1: op = plst_pkg::OP_DEL_BACK;
               default: op = plst_pkg::OP_DEL_POS;
            endcase
            queue_request(op, pick_value(),
                          (op == plst_pkg::OP_DEL_POS)
                             ? pick_position((fill_level > 0) ? fill_level - 1 : 0)
                             : $urandom_range(0, 255));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_total < queued_total || expected_outcomes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
